### src/gccc_pkg.sv
`default_nettype none

package gccc_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_OPENING = 3'd1,
      MODE_CLOSING = 3'd2,
      MODE_HOLDING = 3'd3,
      MODE_HOMING  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      FUNC_HOME  = 2'd0,
      FUNC_OPEN  = 2'd1,
      FUNC_CLOSE = 2'd2,
      FUNC_TICK  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_DIRECTION_NEGATIVE      = 3'd0,
      CSR_STROKE_LENGTH           = 3'd1,
      CSR_FEEDFORWARD_TORQUE      = 3'd2,
      CSR_GRIP_TORQUE             = 3'd3,
      CSR_HOMING_TORQUE           = 3'd4,
      CSR_STALL_SPEED_LIMIT       = 3'd5,
      CSR_STALL_TICKS_NEEDED      = 3'd6,
      CSR_COLLISION_CURRENT_LIMIT = 3'd7
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int REQ_DATA_W  = 80;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 64;

   localparam int WIDE_W = 36;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam wide_type SAT_HI        = 36'sh0_7FFF_FFFF;
   localparam wide_type SAT_LO        = 36'shF_8000_0000;
   localparam wide_type OVERCLOSE     = 36'sd13107;
   localparam wide_type ARRIVE_TOL    = 36'sd3277;
   localparam wide_type OPEN_TOL      = 36'sd9830;
   localparam wide_type CLOSED_TOL    = 36'sd3277;
   localparam wide_type HOMING_STEP   = 36'sd262;
   localparam logic [7:0] DEBOUNCE_TICKS = 8'd25;

   typedef struct packed {
      logic               direction_negative;
      logic signed [19:0] stroke_length;
      logic        [18:0] feedforward_torque;
      logic        [18:0] grip_torque;
      logic        [18:0] homing_torque;
      logic        [18:0] stall_speed_limit;
      logic        [15:0] stall_ticks_needed;
      logic        [13:0] collision_current_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      direction_negative:      1'b1,
      stroke_length:           20'sd32768,
      feedforward_torque:      19'd13107,
      grip_torque:             19'd65536,
      homing_torque:           19'd11796,
      stall_speed_limit:       19'd3277,
      stall_ticks_needed:      16'd50,
      collision_current_limit: 14'd3000
   };

   typedef struct packed {
      func_type           func;
      logic signed [31:0] measured_angle;
      logic signed [31:0] measured_speed;
      logic signed [14:0] measured_current;
   } item_type;

   typedef struct packed {
      logic signed [31:0] position_reference;
      logic signed [19:0] torque_reference;
      mode_type           mode;
      logic signed [31:0] zero_offset;
      logic signed [31:0] last_angle;
   } snap_type;

   function automatic logic signed [31:0] sat32(input wide_type v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [19:0] signed_torque(input logic [18:0] mag,
                                                        input logic neg);
      logic signed [19:0] m;
      m = $signed({1'b0, mag});
      return neg ? -m : m;
   endfunction

   function automatic wide_type dir_stroke(input logic dn,
                                           input logic signed [19:0] stroke);
      wide_type s;
      s = wide_type'(stroke);
      return dn ? -s : s;
   endfunction

   function automatic logic in_band(input wide_type diff, input wide_type tol);
      return (diff > -tol) && (diff < tol);
   endfunction

endpackage

`default_nettype wire

### src/gccc_update.sv
`default_nettype none

module gccc_update import gccc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     enable,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output snap_type      snap_ff
);

   mode_type           mode_ff, mode_in;
   logic signed [31:0] zero_offset_ff, zero_offset_in;
   logic               first_close_tick_ff, first_close_tick_in;
   logic        [7:0]  close_tick_count_ff, close_tick_count_in;
   logic signed [31:0] homing_target_ff, homing_target_in;
   logic        [15:0] stall_count_ff, stall_count_in;
   logic signed [31:0] last_angle_ff, last_angle_in;
   logic signed [31:0] position_command_ff, position_command_in;
   logic signed [19:0] torque_command_ff, torque_command_in;

   wide_type    dstroke, open_tgt, close_tgt, ang_w, spd_w, cur_w;
   wide_type    lim_w, lim2_w, clim_w;
   logic        dn, zpos, slow, slow2, hot, home_done;
   logic [15:0] need, stall_next;
   logic [7:0]  cnt_inc;

   always_comb begin
      dn        = cfg.direction_negative;
      dstroke   = dir_stroke(dn, cfg.stroke_length);
      open_tgt  = wide_type'(zero_offset_ff) - dstroke;
      close_tgt = wide_type'(zero_offset_ff) + (dn ? -OVERCLOSE : OVERCLOSE);
      ang_w     = wide_type'(item.measured_angle);
      spd_w     = wide_type'(item.measured_speed);
      cur_w     = wide_type'(item.measured_current);
      lim_w     = wide_type'({1'b0, cfg.stall_speed_limit});
      lim2_w    = wide_type'({1'b0, cfg.stall_speed_limit, 1'b0});
      clim_w    = wide_type'({1'b0, cfg.collision_current_limit});
      slow      = in_band(spd_w, lim_w);
      slow2     = in_band(spd_w, lim2_w);
      hot       = (cur_w > clim_w) || (cur_w < -clim_w);
      zpos      = dn ^ cfg.stroke_length[19];
      need      = (cfg.stall_ticks_needed == '0) ? 16'd1 : cfg.stall_ticks_needed;
      if (!slow) begin
         stall_next = '0;
      end else if (stall_count_ff == '1) begin
         stall_next = stall_count_ff;
      end else begin
         stall_next = stall_count_ff + 16'd1;
      end
      home_done = stall_next >= need;
      cnt_inc   = (close_tick_count_ff == '1) ? close_tick_count_ff
                                               : close_tick_count_ff + 8'd1;

      mode_in             = mode_ff;
      zero_offset_in      = zero_offset_ff;
      first_close_tick_in = first_close_tick_ff;
      close_tick_count_in = close_tick_count_ff;
      homing_target_in    = homing_target_ff;
      stall_count_in      = stall_count_ff;
      last_angle_in       = last_angle_ff;
      position_command_in = position_command_ff;
      torque_command_in   = torque_command_ff;

      if (item.func == FUNC_TICK) begin
         last_angle_in = item.measured_angle;
         unique case (mode_ff)
            MODE_HOMING: begin
               homing_target_in    = sat32(wide_type'(homing_target_ff)
                                           + (zpos ? HOMING_STEP : -HOMING_STEP));
               position_command_in = homing_target_in;
               torque_command_in   = signed_torque(cfg.homing_torque, !zpos);
               stall_count_in      = stall_next;
               if (home_done) begin
                  zero_offset_in      = sat32(ang_w + dstroke);
                  position_command_in = item.measured_angle;
                  torque_command_in   = '0;
                  mode_in             = MODE_IDLE;
               end
            end
            MODE_OPENING: begin
               if (in_band(open_tgt - ang_w, ARRIVE_TOL)) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_CLOSING: begin
               if (first_close_tick_ff) begin
                  first_close_tick_in = 1'b0;
                  close_tick_count_in = '0;
               end else begin
                  close_tick_count_in = cnt_inc;
                  if (in_band(close_tgt - ang_w, ARRIVE_TOL)) begin
                     mode_in = MODE_IDLE;
                  end else if (cnt_inc > DEBOUNCE_TICKS && hot && slow2) begin
                     if (dn ? (item.measured_angle < zero_offset_ff)
                            : (item.measured_angle > zero_offset_ff)) begin
                        zero_offset_in = item.measured_angle;
                     end
                     mode_in             = MODE_HOLDING;
                     position_command_in = item.measured_angle;
                     torque_command_in   = signed_torque(cfg.grip_torque, dn);
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (mode_ff != MODE_HOMING) begin
         unique case (item.func)
            FUNC_HOME: begin
               mode_in          = MODE_HOMING;
               stall_count_in   = '0;
               homing_target_in = last_angle_ff;
            end
            FUNC_OPEN: begin
               if (mode_ff != MODE_OPENING) begin
                  mode_in             = MODE_OPENING;
                  position_command_in = sat32(open_tgt);
                  torque_command_in   = signed_torque(cfg.feedforward_torque, !dn);
               end
            end
            FUNC_CLOSE: begin
               if (mode_ff != MODE_CLOSING && mode_ff != MODE_HOLDING) begin
                  mode_in             = MODE_CLOSING;
                  position_command_in = sat32(close_tgt);
                  torque_command_in   = signed_torque(cfg.feedforward_torque, dn);
                  first_close_tick_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff             <= MODE_IDLE;
         zero_offset_ff      <= '0;
         first_close_tick_ff <= 1'b1;
         close_tick_count_ff <= '0;
         homing_target_ff    <= '0;
         stall_count_ff      <= '0;
         last_angle_ff       <= '0;
         position_command_ff <= '0;
         torque_command_ff   <= '0;
      end else if (enable) begin
         mode_ff             <= mode_in;
         zero_offset_ff      <= zero_offset_in;
         first_close_tick_ff <= first_close_tick_in;
         close_tick_count_ff <= close_tick_count_in;
         homing_target_ff    <= homing_target_in;
         stall_count_ff      <= stall_count_in;
         last_angle_ff       <= last_angle_in;
         position_command_ff <= position_command_in;
         torque_command_ff   <= torque_command_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         snap_ff.position_reference <= position_command_in;
         snap_ff.torque_reference   <= torque_command_in;
         snap_ff.mode               <= mode_in;
         snap_ff.zero_offset        <= zero_offset_in;
         snap_ff.last_angle         <= last_angle_in;
      end
   end

endmodule

`default_nettype wire

### src/gripper_close_collision_controller.sv
// An accepted req beat passes the input register, the state update register
// and the flag and output register, in that order, to become its rsp beat.
// Throughput: one beat per cycle unless rsp_tready stalls; each update is one step.
// Reset: synchronous, active high; clears the mode and all tracked state,
// empties the pipeline and restores every configuration register default.
`default_nettype none

module gripper_close_collision_controller import gccc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // measured_angle[31:0], measured_speed[63:32], measured_current[78:64]
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // func[1:0]
   input  wire logic [REQ_USER_W-1:0]  req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // position_reference[31:0], torque_reference[51:32], mode_code[54:52],
   // holding_flag[55], open_flag[56], closed_flag[57]
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type  cfg_ff;
   item_type item_ff;
   snap_type snap;
   logic     valid_a_ff, valid_b_ff, valid_c_ff;
   logic     load_c, advance_b;
   logic     open_in, closed_in;
   wide_type open_diff, closed_diff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   assign csr_ready  = 1'b1;
   assign load_c     = valid_b_ff && (!valid_c_ff || rsp_tready);
   assign advance_b  = valid_a_ff && (!valid_b_ff || load_c);
   assign req_tready = !valid_a_ff || advance_b;
   assign rsp_tvalid = valid_c_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIRECTION_NEGATIVE:      cfg_ff.direction_negative      <= csr_data[0];
            CSR_STROKE_LENGTH:           cfg_ff.stroke_length           <= csr_data[19:0];
            CSR_FEEDFORWARD_TORQUE:      cfg_ff.feedforward_torque      <= csr_data[18:0];
            CSR_GRIP_TORQUE:             cfg_ff.grip_torque             <= csr_data[18:0];
            CSR_HOMING_TORQUE:           cfg_ff.homing_torque           <= csr_data[18:0];
            CSR_STALL_SPEED_LIMIT:       cfg_ff.stall_speed_limit       <= csr_data[18:0];
            CSR_STALL_TICKS_NEEDED:      cfg_ff.stall_ticks_needed      <= csr_data[15:0];
            CSR_COLLISION_CURRENT_LIMIT: cfg_ff.collision_current_limit <= csr_data[13:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            valid_a_ff <= req_tvalid;
         end
         if (!valid_b_ff || load_c) begin
            valid_b_ff <= advance_b;
         end
         if (!valid_c_ff || rsp_tready) begin
            valid_c_ff <= load_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.func             <= func_type'(req_tuser[1:0]);
         item_ff.measured_angle   <= req_tdata[31:0];
         item_ff.measured_speed   <= req_tdata[63:32];
         item_ff.measured_current <= req_tdata[78:64];
      end
   end

   gccc_update u_update (
      .clock   (clock),
      .reset   (reset),
      .enable  (advance_b),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .snap_ff (snap)
   );

   always_comb begin
      open_diff   = wide_type'(snap.zero_offset)
                    - dir_stroke(cfg_ff.direction_negative, cfg_ff.stroke_length)
                    - wide_type'(snap.last_angle);
      closed_diff = cfg_ff.direction_negative
                    ? wide_type'(snap.zero_offset) - wide_type'(snap.last_angle)
                    : wide_type'(snap.last_angle) - wide_type'(snap.zero_offset);
      open_in     = in_band(open_diff, OPEN_TOL);
      closed_in   = (snap.mode == MODE_HOLDING) || (closed_diff > -CLOSED_TOL);
      rsp_tdata_in = {6'd0, closed_in, open_in, snap.mode == MODE_HOLDING,
                      snap.mode, snap.torque_reference, snap.position_reference};
   end

   always_ff @(posedge clock) begin
      if (load_c) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

endmodule

`default_nettype wire

### src/gccc_checker.sv
`default_nettype none

module gccc_checker import gccc_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_holding_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55] == (rsp_tdata[54:52] == MODE_HOLDING))
      else $error("holding flag disagrees with mode");

   a_holding_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[55] |-> rsp_tdata[57])
      else $error("holding without closed flag");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp beat present right after reset");

endmodule

bind gripper_close_collision_controller gccc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### bench/gripper_close_collision_checker.sv
`timescale 1ns / 1ps

module gripper_close_collision_checker import gccc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [REQ_USER_W-1:0]  req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int                          fail_count,
   output int                          outstanding
);

   localparam longint OVERSHOOT    = 13107;
   localparam longint ARRIVAL_BAND = 3277;
   localparam longint OPEN_BAND    = 9830;
   localparam longint CLOSED_BAND  = 3277;
   localparam longint HOME_STEP    = 262;
   localparam int     DEBOUNCE     = 25;
   localparam longint POS_MAX      = 64'sd2147483647;
   localparam longint POS_MIN      = -64'sd2147483648;

   typedef struct packed {
      logic [31:0] position;
      logic [19:0] torque;
      logic [2:0]  mode;
      logic        holding;
      logic        at_open;
      logic        at_closed;
   } grip_report_type;

   cfg_type  cfg;
   mode_type grip_mode;
   longint   zero_pos;
   longint   homing_pos;
   longint   last_pos;
   longint   pos_cmd;
   longint   torque_cmd;
   bit       first_close;
   int       close_ticks;
   int       stall_ticks;
   int       mismatches = 0;

   grip_report_type pending_reports[$];

   function automatic longint clamp32(longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint dir_sign();
      return cfg.direction_negative ? -64'sd1 : 64'sd1;
   endfunction

   function automatic longint stroke_of();
      longint s;
      s = $signed(cfg.stroke_length);
      return s;
   endfunction

   function automatic void advance_tick(longint angle, longint speed, longint current);
      longint d, s, zdir, need, speed_lim, cur_lim, tq;
      d = dir_sign();
      s = stroke_of();
      speed_lim = cfg.stall_speed_limit;
      cur_lim = cfg.collision_current_limit;
      last_pos = angle;
      case (grip_mode)
         MODE_HOMING: begin
            zdir = (s >= 0) ? -d : d;
            need = cfg.stall_ticks_needed;
            if (need == 0) need = 1;
            tq = cfg.homing_torque;
            homing_pos = clamp32(homing_pos + zdir * HOME_STEP);
            pos_cmd = homing_pos;
            torque_cmd = zdir * tq;
            if (magnitude(speed) < speed_lim) begin
               if (stall_ticks < 65535) stall_ticks++;
            end else begin
               stall_ticks = 0;
            end
            if (stall_ticks >= need) begin
               zero_pos = clamp32(angle + d * s);
               pos_cmd = angle;
               torque_cmd = 0;
               grip_mode = MODE_IDLE;
            end
         end
         MODE_OPENING: begin
            if (magnitude(zero_pos - d * s - angle) < ARRIVAL_BAND) grip_mode = MODE_IDLE;
         end
         MODE_CLOSING: begin
            if (first_close) begin
               first_close = 1'b0;
               close_ticks = 0;
               return;
            end
            if (close_ticks < 255) close_ticks++;
            if (magnitude(zero_pos + d * OVERSHOOT - angle) < ARRIVAL_BAND) begin
               grip_mode = MODE_IDLE;
               return;
            end
            if (close_ticks > DEBOUNCE && magnitude(current) > cur_lim &&
                magnitude(speed) < 2 * speed_lim) begin
               if (d * (angle - zero_pos) > 0) zero_pos = angle;
               tq = cfg.grip_torque;
               grip_mode = MODE_HOLDING;
               pos_cmd = angle;
               torque_cmd = d * tq;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic grip_report_type step_gripper(func_type f, longint angle,
                                                    longint speed, longint current);
      grip_report_type r;
      longint d, s, ff;
      d = dir_sign();
      s = stroke_of();
      ff = cfg.feedforward_torque;
      if (f == FUNC_TICK) begin
         advance_tick(angle, speed, current);
      end else if (grip_mode != MODE_HOMING) begin
         case (f)
            FUNC_HOME: begin
               grip_mode = MODE_HOMING;
               stall_ticks = 0;
               homing_pos = last_pos;
            end
            FUNC_OPEN: begin
               if (grip_mode != MODE_OPENING) begin
                  grip_mode = MODE_OPENING;
                  pos_cmd = clamp32(zero_pos - d * s);
                  torque_cmd = -d * ff;
               end
            end
            default: begin
               if (grip_mode != MODE_CLOSING && grip_mode != MODE_HOLDING) begin
                  grip_mode = MODE_CLOSING;
                  pos_cmd = clamp32(zero_pos + d * OVERSHOOT);
                  torque_cmd = d * ff;
                  first_close = 1'b1;
               end
            end
         endcase
      end
      r.position  = pos_cmd[31:0];
      r.torque    = torque_cmd[19:0];
      r.mode      = grip_mode;
      r.holding   = (grip_mode == MODE_HOLDING);
      r.at_open   = magnitude(zero_pos - d * s - last_pos) < OPEN_BAND;
      r.at_closed = (grip_mode == MODE_HOLDING) || (d * (last_pos - zero_pos) > -CLOSED_BAND);
      return r;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      grip_report_type want;
      if (reset) begin
         cfg         = CFG_RESET;
         grip_mode   = MODE_IDLE;
         zero_pos    = 0;
         homing_pos  = 0;
         last_pos    = 0;
         pos_cmd     = 0;
         torque_cmd  = 0;
         first_close = 1'b1;
         close_ticks = 0;
         stall_ticks = 0;
         pending_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_DIRECTION_NEGATIVE:      cfg.direction_negative = csr_data[0];
               CSR_STROKE_LENGTH:           cfg.stroke_length = csr_data[19:0];
               CSR_FEEDFORWARD_TORQUE:      cfg.feedforward_torque = csr_data[18:0];
               CSR_GRIP_TORQUE:             cfg.grip_torque = csr_data[18:0];
               CSR_HOMING_TORQUE:           cfg.homing_torque = csr_data[18:0];
               CSR_STALL_SPEED_LIMIT:       cfg.stall_speed_limit = csr_data[18:0];
               CSR_STALL_TICKS_NEEDED:      cfg.stall_ticks_needed = csr_data[15:0];
               CSR_COLLISION_CURRENT_LIMIT: cfg.collision_current_limit = csr_data[13:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            pending_reports.push_back(step_gripper(func_type'(req_tuser),
                                                   $signed(req_tdata[31:0]),
                                                   $signed(req_tdata[63:32]),
                                                   $signed(req_tdata[78:64])));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reports.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected, expected none, actual %0h",
                        $time, rsp_tdata);
            end else begin
               want = pending_reports.pop_front();
               check_field("position_reference", want.position, rsp_tdata[31:0]);
               check_field("torque_reference", want.torque, rsp_tdata[51:32]);
               check_field("mode_code", want.mode, rsp_tdata[54:52]);
               check_field("holding_flag", want.holding, rsp_tdata[55]);
               check_field("open_flag", want.at_open, rsp_tdata[56]);
               check_field("closed_flag", want.at_closed, rsp_tdata[57]);
            end
         end
      end
      fail_count  <= mismatches;
      outstanding <= pending_reports.size();
   end

endmodule

### bench/gripper_close_collision_controller_tb.sv
`timescale 1ns / 1ps

module gripper_close_collision_controller_tb import gccc_pkg::*;;

   localparam int     CYCLE_LIMIT = 500000;
   localparam longint POS_MAX     = 64'sd2147483647;
   localparam longint POS_MIN     = -64'sd2147483648;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = FUNC_HOME;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_DIRECTION_NEGATIVE;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int fail_count;
   int outstanding;
   int cycle_count = 0;
   int sent = 0;
   int stall_left = 0;
   int flow_left = 0;
   bit calm = 1'b0;
   bit quiet = 1'b0;

   logic   dir_neg    = 1'b1;
   longint stroke_len = 32768;
   longint stall_lim  = 3277;
   longint stall_need = 50;
   longint cur_lim    = 3000;
   longint zero_guess = 0;

   gripper_close_collision_controller dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   gripper_close_collision_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (flow_left > 0) begin
         flow_left  <= flow_left - 1;
         rsp_tready <= 1'b1;
      end else begin
         stall_left <= $urandom_range(0, 9);
         flow_left  <= $urandom_range(0, 40);
         rsp_tready <= 1'b0;
      end
   end

   function automatic longint pick_near(longint base, int spread);
      longint v;
      v = base + longint'($urandom_range(0, 2 * spread)) - spread;
      if (v > POS_MAX) v = POS_MAX;
      else if (v < POS_MIN) v = POS_MIN;
      return v;
   endfunction

   function automatic longint flip(longint v);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   task automatic send_beat(input func_type f, input longint angle, input longint speed,
                            input longint current, input bit counted);
      if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {1'b0, current[14:0], speed[31:0], angle[31:0]};
      do @(posedge clock); while (!req_tready);
      if (counted) sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [19:0] value);
      case (idx)
         CSR_DIRECTION_NEGATIVE:      dir_neg = value[0];
         CSR_STROKE_LENGTH:           stroke_len = $signed(value);
         CSR_STALL_SPEED_LIMIT:       stall_lim = value[18:0];
         CSR_STALL_TICKS_NEEDED:      stall_need = value[15:0];
         CSR_COLLISION_CURRENT_LIMIT: cur_lim = value[13:0];
         default: ;
      endcase
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic apply_settings(input int phase);
      logic [19:0] vals [8];
      case (phase)
         0: begin
            vals[CSR_DIRECTION_NEGATIVE]      = 20'd1;
            vals[CSR_STROKE_LENGTH]           = 20'd32768;
            vals[CSR_FEEDFORWARD_TORQUE]      = 20'd13107;
            vals[CSR_GRIP_TORQUE]             = 20'd65536;
            vals[CSR_HOMING_TORQUE]           = 20'd11796;
            vals[CSR_STALL_SPEED_LIMIT]       = 20'd3277;
            vals[CSR_STALL_TICKS_NEEDED]      = 20'd50;
            vals[CSR_COLLISION_CURRENT_LIMIT] = 20'd3000;
         end
         1: begin
            vals[CSR_DIRECTION_NEGATIVE]      = 20'd0;
            vals[CSR_STROKE_LENGTH]           = 20'h7FFFF;
            vals[CSR_FEEDFORWARD_TORQUE]      = 20'h7FFFF;
            vals[CSR_GRIP_TORQUE]             = 20'd0;
            vals[CSR_HOMING_TORQUE]           = 20'h7FFFF;
            vals[CSR_STALL_SPEED_LIMIT]       = 20'h7FFFF;
            vals[CSR_STALL_TICKS_NEEDED]      = 20'd1;
            vals[CSR_COLLISION_CURRENT_LIMIT] = 20'd0;
         end
         2: begin
            vals[CSR_DIRECTION_NEGATIVE]      = 20'd1;
            vals[CSR_STROKE_LENGTH]           = 20'h80000;
            vals[CSR_FEEDFORWARD_TORQUE]      = 20'd0;
            vals[CSR_GRIP_TORQUE]             = 20'h7FFFF;
            vals[CSR_HOMING_TORQUE]           = 20'd0;
            vals[CSR_STALL_SPEED_LIMIT]       = 20'd0;
            vals[CSR_STALL_TICKS_NEEDED]      = 20'hFFFF;
            vals[CSR_COLLISION_CURRENT_LIMIT] = 20'h3FFF;
         end
         default: begin
            vals[CSR_DIRECTION_NEGATIVE] = $urandom_range(0, 20'hFFFFF);
            if (phase == 3) begin
               vals[CSR_STROKE_LENGTH] = 20'd0;
            end else if ($urandom_range(0, 1)) begin
               vals[CSR_STROKE_LENGTH] = $urandom_range(0, 20'hFFFFF);
            end else begin
               vals[CSR_STROKE_LENGTH] = 20'($urandom_range(0, 400000) - 200000);
            end
            vals[CSR_FEEDFORWARD_TORQUE]      = $urandom_range(0, 20'hFFFFF);
            vals[CSR_GRIP_TORQUE]             = $urandom_range(0, 20'hFFFFF);
            vals[CSR_HOMING_TORQUE]           = $urandom_range(0, 20'hFFFFF);
            vals[CSR_STALL_SPEED_LIMIT]       = $urandom_range(500, 200000);
            vals[CSR_STALL_TICKS_NEEDED]      = $urandom_range(1, 10);
            vals[CSR_COLLISION_CURRENT_LIMIT] = $urandom_range(0, 16383);
         end
      endcase
      for (int i = 0; i < 8; i++) write_reg(csr_index_type'(i), vals[i]);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int goal);
      longint d, a, open_t, lim2, cur;
      int target, n, k;
      target = sent + goal;
      while (sent < target) begin
         quiet  = ($urandom_range(0, 4) == 0);
         d      = dir_neg ? -64'sd1 : 64'sd1;
         open_t = pick_near(zero_guess - d * stroke_len, 0);
         case ($urandom_range(0, 9))
            0, 1: begin
               send_beat(FUNC_HOME, 0, 0, 0, 1'b1);
               n = $urandom_range(0, 4);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(0, 2) == 0) begin
                     send_beat(func_type'($urandom_range(0, 2)), 0, 0, 0, 1'b0);
                  end
                  send_beat(FUNC_TICK, pick_near(zero_guess, 50000),
                            flip(stall_lim + $urandom_range(0, 100000)),
                            flip($urandom_range(0, 2000)), 1'b1);
               end
               case ($urandom_range(0, 7))
                  0: a = POS_MAX;
                  1: a = POS_MIN;
                  2: a = $signed($urandom());
                  default: a = pick_near(0, 400000);
               endcase
               k = (stall_need == 0) ? 1 : ((stall_need > 80) ? 80 : int'(stall_need));
               for (int i = 0; i < k; i++) begin
                  send_beat(FUNC_TICK, a,
                            (stall_lim == 0) ? 0 : flip($urandom_range(0, stall_lim - 1)),
                            flip($urandom_range(0, 2000)), 1'b1);
               end
               zero_guess = pick_near(a + d * stroke_len, 0);
            end
            2, 3, 4: begin
               send_beat(FUNC_CLOSE, 0, 0, 0, 1'b1);
               send_beat(FUNC_TICK, pick_near(zero_guess - d * 20000, 20000),
                         flip($urandom_range(0, 5000)), 0, 1'b1);
               if ($urandom_range(0, 2) == 0) begin
                  n = $urandom_range(0, 5);
                  for (int i = 0; i < n; i++) begin
                     send_beat(FUNC_TICK, pick_near(zero_guess - d * 30000, 20000),
                               flip($urandom_range(0, 300000)), 0, 1'b1);
                  end
                  send_beat(FUNC_TICK, pick_near(zero_guess + d * 13107, 3400),
                            flip($urandom_range(0, 300000)), 0, 1'b1);
               end else begin
                  n = $urandom_range(24, 30);
                  for (int i = 0; i < n; i++) begin
                     send_beat(FUNC_TICK, pick_near(zero_guess - d * 40000, 10000),
                               flip($urandom_range(0, 300000)),
                               flip($urandom_range(0, cur_lim)), 1'b1);
                  end
                  lim2 = 2 * stall_lim;
                  for (int i = 0; i < 3; i++) begin
                     a = pick_near(zero_guess +
                                   d * (longint'($urandom_range(0, 26000)) - 20000), 0);
                     cur = (cur_lim < 16383) ? flip($urandom_range(cur_lim + 1, 16383))
                                             : -64'sd16384;
                     send_beat(FUNC_TICK, a,
                               (lim2 == 0) ? 0 : flip($urandom_range(0, lim2 - 1)),
                               cur, 1'b1);
                     if (i == 1 && d * (a - zero_guess) > 0) zero_guess = a;
                  end
                  n = $urandom_range(0, 3);
                  for (int i = 0; i < n; i++) begin
                     send_beat(FUNC_TICK, pick_near(zero_guess, 8000),
                               flip($urandom_range(0, 5000)),
                               flip($urandom_range(0, 16383)), 1'b1);
                  end
                  if ($urandom_range(0, 1)) send_beat(FUNC_OPEN, 0, 0, 0, 1'b1);
               end
            end
            5, 6: begin
               send_beat(FUNC_OPEN, 0, 0, 0, 1'b1);
               n = $urandom_range(0, 4);
               for (int i = 0; i < n; i++) begin
                  send_beat(FUNC_TICK, pick_near(open_t, 60000),
                            flip($urandom_range(0, 300000)), 0, 1'b1);
               end
               send_beat(FUNC_TICK, pick_near(open_t, 3400),
                         flip($urandom_range(0, 300000)), 0, 1'b1);
            end
            7, 8: begin
               n = $urandom_range(3, 8);
               for (int i = 0; i < n; i++) begin
                  send_beat(FUNC_TICK,
                            pick_near($urandom_range(0, 1) ? zero_guess : open_t, 12000),
                            flip($urandom_range(0, 1000000)),
                            longint'($urandom_range(0, 32767)) - 16384, 1'b1);
               end
            end
            default: begin
               n = $urandom_range(1, 6);
               for (int i = 0; i < n; i++) begin
                  send_beat(func_type'($urandom_range(0, 3)), $signed($urandom()),
                            $signed($urandom()),
                            longint'($urandom_range(0, 32767)) - 16384, 1'b1);
               end
            end
         endcase
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_reg(CSR_STALL_TICKS_NEEDED, 20'd0);
      csr_valid <= 1'b0;

      send_beat(FUNC_TICK, POS_MAX, POS_MIN, -16384, 1'b1);
      send_beat(FUNC_TICK, POS_MIN, POS_MAX, 16383, 1'b1);
      send_beat(FUNC_TICK, 0, 0, 0, 1'b1);
      send_beat(FUNC_CLOSE, 0, 0, 0, 1'b1);
      send_beat(FUNC_CLOSE, 0, 0, 0, 1'b1);
      send_beat(FUNC_TICK, -5000, 0, 0, 1'b1);
      send_beat(FUNC_TICK, -13107, 0, 0, 1'b1);
      send_beat(FUNC_OPEN, 0, 0, 0, 1'b1);
      send_beat(FUNC_OPEN, 0, 0, 0, 1'b1);
      send_beat(FUNC_TICK, 30000, 0, 0, 1'b1);
      send_beat(FUNC_CLOSE, 0, 0, 0, 1'b1);
      send_beat(FUNC_TICK, -3000, 0, 0, 1'b1);
      send_beat(FUNC_TICK, 0, 0, 16383, 1'b1);
      send_beat(FUNC_OPEN, 0, 0, 0, 1'b1);
      send_beat(FUNC_TICK, POS_MAX, 1000000, 0, 1'b1);
      send_beat(FUNC_HOME, 0, 0, 0, 1'b1);
      send_beat(FUNC_OPEN, 0, 0, 0, 1'b1);
      send_beat(FUNC_CLOSE, 0, 0, 0, 1'b1);
      send_beat(FUNC_HOME, 0, 0, 0, 1'b1);
      send_beat(FUNC_TICK, POS_MAX, 1000000, 0, 1'b1);
      send_beat(FUNC_TICK, 100000, 0, 0, 1'b1);
      zero_guess = 100000 - 32768;
      send_beat(FUNC_TICK, zero_guess, 0, 0, 1'b1);
      drain();

      for (int p = 0; p < 10; p++) begin
         if (p == 9) calm = 1'b1;
         apply_settings(p);
         case (p)
            0: run_phase(250);
            1: run_phase(200);
            2: run_phase(100);
            9: run_phase(200);
            default: run_phase(160);
         endcase
         drain();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
